@@ hw/rtl/acsc_pkg.sv @@
// Package for the ASCII clock / stopwatch counter.
// Holds character constants, request and mode codes, and the digit step helper.
// No dependencies.
`default_nettype none

package acsc_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned NUM_CHARS  = 8;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned BUF_W      = CHAR_W * NUM_CHARS;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
    localparam logic [CHAR_W-1:0] CH_FIVE  = 8'h35;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0]
    {
        REQ_SEC_TICK   = 2'd0,
        REQ_FAST_TICK  = 2'd1,
        REQ_LOAD_CLOCK = 2'd2,
        REQ_LOAD_SW    = 2'd3
    } req_type_t;

    typedef enum logic [1:0]
    {
        MODE_IDLE    = 2'd0,
        MODE_TOD     = 2'd1,
        MODE_SW_MS   = 2'd2,
        MODE_SW_LONG = 2'd3
    } count_mode_t;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed
    {
        logic  carry;
        char_t value;
    } bump_t;

    // One digit step: below the limit it counts up, otherwise back to '0' with carry.
    function automatic bump_t digit_bump(input char_t d, input char_t limit);
        bump_t r;
        if (d < limit)
        begin
            r.value = d + 8'd1;
            r.carry = 1'b0;
        end
        else
        begin
            r.value = CH_ZERO;
            r.carry = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/acsc_if.sv @@
// Handshake channel interfaces for the ASCII clock / stopwatch counter.
// Request, result and mode-write channels; each carries valid, ready and payload.
// Depends on acsc_pkg.
`default_nettype none

interface acsc_req_if
    import acsc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [IDX_W-1:0]     digit_index;
    logic [CHAR_W-1:0]    digit_value;

    modport source (output valid, output req_type, output digit_index, output digit_value,
                    input ready);
    modport sink   (input valid, input req_type, input digit_index, input digit_value,
                    output ready);
endinterface

interface acsc_rsp_if
    import acsc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BUF_W-1:0]     clock_chars;
    logic [BUF_W-1:0]     stopwatch_chars;

    modport source (output valid, output clock_chars, output stopwatch_chars, input ready);
    modport sink   (input valid, input clock_chars, input stopwatch_chars, output ready);
endinterface

interface acsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] count_mode;

    modport source (output valid, output count_mode, input ready);
    modport sink   (input valid, input count_mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ascii_clock_stopwatch_counter.sv @@
// ASCII clock / stopwatch counter, top level. Depends on acsc_pkg and acsc_if.sv.
// A request passes through the request register, then the result register, before its result
// can transfer; result valid rises as it enters the result register, unless a stall holds it.
// Throughput: 1 request per cycle without result stalls; the carry cascade is combinational.
// The result register is the pair of character buffers itself.
// Reset (rst_n low, async): both buffers to all '0', timer mode idle, pipeline empty.
`default_nettype none

module ascii_clock_stopwatch_counter
    import acsc_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    acsc_req_if.sink     req,
    acsc_rsp_if.source   rsp,
    acsc_cfg_if.sink     cfg
);

    // ------------------------------------------------------------------
    // Mode register. The user must write it only while idle; the block does not enforce it. Always ready.
    // ------------------------------------------------------------------
    count_mode_t mode_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            mode_reg <= count_mode_t'(cfg.count_mode);
        end
    end

    // ------------------------------------------------------------------
    // Request register (stage 1).
    // ------------------------------------------------------------------
    logic              in_vld_reg;
    req_type_t         in_type_reg;
    logic [IDX_W-1:0]  in_idx_reg;
    char_t             in_val_reg;

    logic              out_vld_reg;
    logic              out_free;    // result slot can take a new item this cycle
    logic              adv;         // stage 1 item moves into the result register
    logic              in_take;     // request transfer this cycle

    assign out_free = !out_vld_reg || rsp.ready;
    assign adv      = in_vld_reg && out_free;
    assign req.ready = !in_vld_reg || out_free;
    assign in_take  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_type_reg <= req_type_t'(req.req_type);
            in_idx_reg  <= req.digit_index;
            in_val_reg  <= req.digit_value;
        end
    end

    // ------------------------------------------------------------------
    // Character buffers (stage 2 / result). They only change when an item
    // enters the result slot, so they hold the last result while it waits.
    // ------------------------------------------------------------------
    char_t clock_reg [NUM_CHARS];
    char_t sw_reg    [NUM_CHARS];
    char_t clock_next [NUM_CHARS];
    char_t sw_next    [NUM_CHARS];

    always_comb
    begin
        bump_t s;
        clock_next = clock_reg;
        sw_next    = sw_reg;
        s          = '0;
        case (in_type_reg)
            REQ_SEC_TICK:
            begin
                case (mode_reg)
                    MODE_TOD:
                    begin
                        // ss at 1:0, mm at 4:3, hh at 7:6; separators 2 and 5 untouched
                        s = digit_bump(clock_reg[0], CH_NINE);
                        clock_next[0] = s.value;
                        if (s.carry)
                        begin
                            s = digit_bump(clock_reg[1], CH_FIVE);
                            clock_next[1] = s.value;
                            if (s.carry)
                            begin
                                s = digit_bump(clock_reg[3], CH_NINE);
                                clock_next[3] = s.value;
                                if (s.carry)
                                begin
                                    s = digit_bump(clock_reg[4], CH_FIVE);
                                    clock_next[4] = s.value;
                                    if (s.carry)
                                    begin
                                        // hours: tens digit picks the units limit
                                        if (clock_reg[7] == CH_ZERO || clock_reg[7] == CH_ONE)
                                        begin
                                            s = digit_bump(clock_reg[6], CH_NINE);
                                            clock_next[6] = s.value;
                                            if (s.carry)
                                            begin
                                                clock_next[7] = clock_reg[7] + 8'd1;
                                            end
                                        end
                                        else if (clock_reg[7] == CH_TWO)
                                        begin
                                            // 23 -> 00 wrap
                                            s = digit_bump(clock_reg[6], CH_THREE);
                                            clock_next[6] = s.value;
                                            if (s.carry)
                                            begin
                                                clock_next[7] = CH_ZERO;
                                            end
                                        end
                                        // any other tens byte: hours frozen
                                    end
                                end
                            end
                        end
                    end
                    MODE_SW_MS:
                    begin
                        s = digit_bump(sw_reg[3], CH_NINE);
                        sw_next[3] = s.value;
                        if (s.carry)
                        begin
                            s = digit_bump(sw_reg[4], CH_FIVE);
                            sw_next[4] = s.value;
                            if (s.carry)
                            begin
                                s = digit_bump(sw_reg[6], CH_NINE);
                                sw_next[6] = s.value;
                                if (s.carry)
                                begin
                                    s = digit_bump(sw_reg[7], CH_FIVE);
                                    sw_next[7] = s.value;
                                end
                            end
                        end
                    end
                    MODE_SW_LONG:
                    begin
                        s = digit_bump(sw_reg[2], CH_NINE);
                        sw_next[2] = s.value;
                        if (s.carry)
                        begin
                            s = digit_bump(sw_reg[3], CH_FIVE);
                            sw_next[3] = s.value;
                            if (s.carry)
                            begin
                                s = digit_bump(sw_reg[5], CH_NINE);
                                sw_next[5] = s.value;
                                if (s.carry)
                                begin
                                    s = digit_bump(sw_reg[6], CH_FIVE);
                                    sw_next[6] = s.value;
                                    if (s.carry)
                                    begin
                                        s = digit_bump(sw_reg[7], CH_NINE);
                                        sw_next[7] = s.value;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        // idle: no change
                    end
                endcase
            end
            REQ_FAST_TICK:
            begin
                case (mode_reg)
                    MODE_SW_LONG:
                    begin
                        s = digit_bump(sw_reg[0], CH_NINE);
                        sw_next[0] = s.value;
                    end
                    MODE_SW_MS:
                    begin
                        // hundredths: two digits with carry
                        s = digit_bump(sw_reg[0], CH_NINE);
                        sw_next[0] = s.value;
                        if (s.carry)
                        begin
                            s = digit_bump(sw_reg[1], CH_NINE);
                            sw_next[1] = s.value;
                        end
                    end
                    default:
                    begin
                        // idle or time of day: no change
                    end
                endcase
            end
            REQ_LOAD_CLOCK:
            begin
                clock_next[in_idx_reg] = in_val_reg;
            end
            REQ_LOAD_SW:
            begin
                sw_next[in_idx_reg] = in_val_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            for (int i = 0; i < NUM_CHARS; i++)
            begin
                clock_reg[i] <= CH_ZERO;
                sw_reg[i]    <= CH_ZERO;
            end
        end
        else
        begin
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (adv)
            begin
                clock_reg <= clock_next;
                sw_reg    <= sw_next;
            end
        end
    end

    // Pack, position 0 in the low byte.
    always_comb
    begin
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            rsp.clock_chars[i*CHAR_W +: CHAR_W]     = clock_reg[i];
            rsp.stopwatch_chars[i*CHAR_W +: CHAR_W] = sw_reg[i];
        end
    end

    assign rsp.valid = out_vld_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Buffers change only when an item enters the result slot.
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(rsp.clock_chars) && $stable(rsp.stopwatch_chars)))
        else $error("buffers changed without a transfer into the result slot");

    // Ticks never touch clock separator positions.
    a_sep_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (in_type_reg == REQ_SEC_TICK || in_type_reg == REQ_FAST_TICK))
        |=> ($stable(clock_reg[2]) && $stable(clock_reg[5])))
        else $error("tick modified a clock separator");

    // Request side stalls only with a full stage 1 behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (in_vld_reg && out_vld_reg && !rsp.ready))
        else $error("request side stalled without backpressure");

endmodule

`default_nettype wire

@@ verif/tb_ascii_clock_stopwatch_counter.sv @@
// Testbench for ascii_clock_stopwatch_counter: directed and random request traffic.
// A built-in predictor tracks both character buffers and checks every result transfer.
// Depends on acsc_pkg, acsc_if.sv and the RTL top level.
`timescale 1ns / 100ps

module tb_ascii_clock_stopwatch_counter;
    import acsc_pkg::*;

    // Generous bound: ~1400 items, each with worst-case sender gap and receiver stall,
    // plus the drains around every mode write, taken several times over.
    localparam int CYCLE_LIMIT  = 600_000;
    // Spare cycles past the request and result registers, before a mode write and at the end.
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 120;

    // One result transfer: both buffers, position 0 in the low byte.
    typedef struct packed
    {
        logic [BUF_W-1:0] clock_chars;
        logic [BUF_W-1:0] stopwatch_chars;
    } display_t;

    logic clk;
    logic rst_n;

    acsc_req_if req_ch ();
    acsc_rsp_if rsp_ch ();
    acsc_cfg_if cfg_ch ();

    ascii_clock_stopwatch_counter dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predicted state of the block.
    char_t       clock_face     [NUM_CHARS];
    char_t       stopwatch_face [NUM_CHARS];
    count_mode_t mode_now;

    // Buffers expected on upcoming result transfers, oldest first.
    display_t    expected_displays [$];
    display_t    oldest_display;

    int error_count;
    int cycle_count;
    int items_sent;
    bit gaps_on;     // cleared for stretches with no idling on either side

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Below the limit a digit counts up; at or above (non-digits too) it goes to '0'.
    function automatic char_t stepped(char_t d, char_t limit);
        return (d < limit) ? char_t'(d + 8'd1) : CH_ZERO;
    endfunction

    // Step one position of a buffer; returns the carry out.
    function automatic bit bump_clock(int pos, char_t limit);
        bit carry;
        carry           = (clock_face[pos] >= limit);
        clock_face[pos] = stepped(clock_face[pos], limit);
        return carry;
    endfunction

    function automatic bit bump_sw(int pos, char_t limit);
        bit carry;
        carry               = (stopwatch_face[pos] >= limit);
        stopwatch_face[pos] = stepped(stopwatch_face[pos], limit);
        return carry;
    endfunction

    // 24-hour clock: ss at 1:0, mm at 4:3, hh at 7:6; separators untouched.
    function automatic void tick_time_of_day();
        char_t tens;
        if (!bump_clock(0, CH_NINE)) return;
        if (!bump_clock(1, CH_FIVE)) return;
        if (!bump_clock(3, CH_NINE)) return;
        if (!bump_clock(4, CH_FIVE)) return;
        // Hours depend on the tens byte; any other byte freezes the hours.
        tens = clock_face[7];
        if (tens == CH_ZERO || tens == CH_ONE)
        begin
            if (bump_clock(6, CH_NINE))
                clock_face[7] = char_t'(tens + 8'd1);
        end
        else if (tens == CH_TWO)
        begin
            if (bump_clock(6, CH_THREE))
                clock_face[7] = CH_ZERO;
        end
    endfunction

    function automatic void tick_second();
        bit carry_out;
        case (mode_now)
            MODE_TOD:
                tick_time_of_day();
            MODE_SW_MS:
            begin
                // mm:ss at 7:6 and 4:3, wraps silently
                if (bump_sw(3, CH_NINE) && bump_sw(4, CH_FIVE) && bump_sw(6, CH_NINE))
                    carry_out = bump_sw(7, CH_FIVE);
            end
            MODE_SW_LONG:
            begin
                if (bump_sw(2, CH_NINE) && bump_sw(3, CH_FIVE) && bump_sw(5, CH_NINE)
                    && bump_sw(6, CH_FIVE))
                    carry_out = bump_sw(7, CH_NINE);
            end
            default:
                ;
        endcase
    endfunction

    // Sub-second digits; no effect in idle or time-of-day mode.
    function automatic void tick_fast();
        bit carry_out;
        if (mode_now == MODE_SW_LONG)
            carry_out = bump_sw(0, CH_NINE);
        else if (mode_now == MODE_SW_MS)
        begin
            if (bump_sw(0, CH_NINE))
                carry_out = bump_sw(1, CH_NINE);
        end
    endfunction

    function automatic display_t faces_now();
        display_t d;
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            d.clock_chars[i*CHAR_W +: CHAR_W]     = clock_face[i];
            d.stopwatch_chars[i*CHAR_W +: CHAR_W] = stopwatch_face[i];
        end
        return d;
    endfunction

    // Apply one accepted request and queue the buffers it must show.
    function automatic void advance_counters(req_type_t kind, logic [IDX_W-1:0] idx,
                                             char_t val);
        case (kind)
            REQ_SEC_TICK:   tick_second();
            REQ_FAST_TICK:  tick_fast();
            REQ_LOAD_CLOCK: clock_face[idx] = val;
            default:        stopwatch_face[idx] = val;
        endcase
        expected_displays.push_back(faces_now());
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Digits weighted toward the carry limits, with the odd non-digit byte.
    function automatic char_t pick_char();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return char_t'($urandom_range(0, 255));
        if (r <= 4)
            return CH_NINE;
        if (r <= 6)
            return CH_FIVE;
        if (r == 7)
            return CH_THREE;
        if (r == 8)
            return CH_TWO;
        if (r == 9)
            return CH_ONE;
        return char_t'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    // Tick mix that fits the mode: mostly second ticks in time of day, mostly sub-second in MODE_SW_MS, else even.
    function automatic req_type_t pick_tick(count_mode_t m);
        if (m == MODE_TOD)
        begin
            if ($urandom_range(0, 9) == 0)
                return REQ_FAST_TICK;
            return REQ_SEC_TICK;
        end
        if (m == MODE_SW_MS)
        begin
            if ($urandom_range(0, 2) == 0)
                return REQ_SEC_TICK;
            return REQ_FAST_TICK;
        end
        if ($urandom_range(0, 1) == 0)
            return REQ_SEC_TICK;
        return REQ_FAST_TICK;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // Send one request. valid is left high after the transfer: the next call
    // either reuses it for back-to-back traffic or drops it for a gap, so valid
    // never gets two assignments in one step.
    task automatic send_item(req_type_t kind, int idx, char_t val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.digit_index <= idx[IDX_W-1:0];
        req_ch.digit_value <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        advance_counters(kind, idx[IDX_W-1:0], val);
        items_sent++;
    endtask

    // Drop valid before any wait; the task then waits on the clock before it returns.
    task automatic req_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (expected_displays.size() != 0)
            @(posedge clk);
    endtask

    // Mode writes only with the pipeline empty.
    task automatic cfg_write(count_mode_t m);
        req_idle();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.count_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        mode_now = m;
    endtask

    // hh:mm:ss into clock positions 7,6 / 4,3 / 1,0.
    task automatic set_clock(char_t h1, char_t h0, char_t m1, char_t m0, char_t s1, char_t s0);
        send_item(REQ_LOAD_CLOCK, 7, h1);
        send_item(REQ_LOAD_CLOCK, 6, h0);
        send_item(REQ_LOAD_CLOCK, 4, m1);
        send_item(REQ_LOAD_CLOCK, 3, m0);
        send_item(REQ_LOAD_CLOCK, 1, s1);
        send_item(REQ_LOAD_CLOCK, 0, s0);
    endtask

    // Load most positions of the buffer the mode counts on, separators included,
    // so that carry chains and wraps get reached quickly.
    task automatic preset_faces(count_mode_t m);
        bit on_clock;
        on_clock = (m == MODE_TOD) || (m == MODE_IDLE && $urandom_range(0, 1) == 1);
        for (int pos = 0; pos < NUM_CHARS; pos++)
        begin
            if ($urandom_range(0, 3) != 0)
                send_item(on_clock ? REQ_LOAD_CLOCK : REQ_LOAD_SW, pos, pick_char());
        end
    endtask

    // A preset now and then, a run of ticks, and some arbitrary requests as noise.
    task automatic random_burst(count_mode_t m);
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            preset_faces(m);
        else if (pick == 9)
            send_item(req_type_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                      char_t'($urandom_range(0, 255)));
        n = $urandom_range(1, 20);
        repeat (n)
            send_item(pick_tick(m), $urandom_range(0, 7), char_t'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle mode: ticks change nothing; loads hit both buffers at the index and byte extremes.
    task automatic test_idle_mode();
        cfg_write(MODE_IDLE);
        send_item(REQ_SEC_TICK, 0, CH_ZERO);
        send_item(REQ_FAST_TICK, 7, 8'hFF);
        send_item(REQ_LOAD_CLOCK, 0, 8'hFF);
        send_item(REQ_LOAD_SW, 7, 8'h00);
        send_item(REQ_LOAD_SW, 2, 8'hFF);
    endtask

    task automatic test_time_of_day();
        cfg_write(MODE_TOD);
        // non-digit seconds byte resets to '0' and carries
        send_item(REQ_SEC_TICK, 0, CH_ZERO);
        // midnight wrap
        set_clock(CH_TWO, CH_THREE, CH_FIVE, CH_NINE, CH_FIVE, CH_NINE);
        send_item(REQ_SEC_TICK, 0, CH_ZERO);
        // fast tick does nothing in this mode
        send_item(REQ_FAST_TICK, 3, CH_NINE);
        // hours tens byte that is not '0'..'2': hours must hold
        set_clock(8'h7A, CH_NINE, CH_FIVE, CH_NINE, CH_FIVE, CH_NINE);
        send_item(REQ_SEC_TICK, 0, CH_ZERO);
    endtask

    // Both stopwatch layouts; the stopwatch still holds the non-digit loads.
    task automatic test_stopwatch_layouts();
        cfg_write(MODE_SW_MS);
        send_item(REQ_FAST_TICK, 0, CH_ZERO);
        send_item(REQ_SEC_TICK, 0, CH_ZERO);
        cfg_write(MODE_SW_LONG);
        send_item(REQ_SEC_TICK, 0, CH_ZERO);
        send_item(REQ_FAST_TICK, 0, CH_ZERO);
    endtask

    // Phases over all modes; an occasional full drain mid-phase as pressure.
    task automatic test_random_traffic();
        count_mode_t m;
        int target;
        for (int p = 0; p < 10; p++)
        begin
            m = (p == 3) ? MODE_IDLE : count_mode_t'(p % 3 + 1);
            cfg_write(m);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                random_burst(m);
                if ($urandom_range(0, 39) == 0)
                begin
                    req_idle();
                    wait_drain();
                end
            end
        end
    endtask

    // No gaps and no stalls: full-rate traffic through the pipeline.
    task automatic test_back_to_back();
        int target;
        gaps_on = 1'b0;
        cfg_write(MODE_SW_MS);
        target = items_sent + 180;
        while (items_sent < target)
            random_burst(MODE_SW_MS);
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(string field, logic [BUF_W-1:0] want,
                                   logic [BUF_W-1:0] got);
        $display("[%0t] %s: expected %h, got %h", $time, field, want, got);
        error_count++;
    endtask

    // Receiver stalls, same gap profile as the sender.
    initial
    begin
        int stall;
        stall        = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Every result transfer is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_displays.size() == 0)
                report_mismatch("result with nothing pending", '0, rsp_ch.clock_chars);
            else
            begin
                oldest_display = expected_displays.pop_front();
                if (rsp_ch.clock_chars !== oldest_display.clock_chars)
                    report_mismatch("clock_chars", oldest_display.clock_chars,
                                    rsp_ch.clock_chars);
                if (rsp_ch.stopwatch_chars !== oldest_display.stopwatch_chars)
                    report_mismatch("stopwatch_chars", oldest_display.stopwatch_chars,
                                    rsp_ch.stopwatch_chars);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ascii_clock_stopwatch_counter: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_SEC_TICK;
        req_ch.digit_index = '0;
        req_ch.digit_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.count_mode  = MODE_IDLE;
        error_count        = 0;
        cycle_count        = 0;
        items_sent         = 0;
        gaps_on            = 1'b1;
        mode_now           = MODE_IDLE;
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            clock_face[i]     = CH_ZERO;
            stopwatch_face[i] = CH_ZERO;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_mode();
        test_time_of_day();
        test_stopwatch_layouts();
        test_random_traffic();
        test_back_to_back();

        req_idle();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ascii_clock_stopwatch_counter: match");
        else
            $display("ascii_clock_stopwatch_counter: mismatch");
        $finish;
    end

endmodule
